// ----- sv/keyframe_linear_interpolator_unit_macros.svh -----
// Assertion macros used by the port-level checker file.
`ifndef KEYFRAME_LINEAR_INTERPOLATOR_UNIT_MACROS_SVH
`define KEYFRAME_LINEAR_INTERPOLATOR_UNIT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define KLI_ASSERT_IMP(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define KLI_ASSERT_NEXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("assertion failed");
`endif

// ----- sv/kli_pkg.sv -----
// Package with the types and constants of the keyframe interpolator.
package kli_pkg;
	localparam int MaxKeys = 64;
	localparam int SlotW = $clog2(MaxKeys);
	localparam int CountW = $clog2(MaxKeys + 1);
	localparam logic [31:0] QOne = 32'h0001_0000;
	localparam logic [2:0] ST_INTERP = 3'd0;
	localparam logic [2:0] ST_FIRST = 3'd1;
	localparam logic [2:0] ST_LAST = 3'd2;
	localparam logic [2:0] ST_EMPTY = 3'd3;
	localparam logic [2:0] ST_WRITTEN = 3'd4;
	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_EVAL = 1'b1;
	localparam logic CFG_KEY_COUNT = 1'b0;
	localparam logic CFG_EMPTY_ONE = 1'b1;

	typedef struct packed {
		logic command;
		logic [5:0] key_slot;
		logic [31:0] key_time;
		logic signed [31:0] key_x;
		logic signed [31:0] key_y;
		logic signed [31:0] key_z;
		logic [31:0] query_time;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] out_x;
		logic signed [31:0] out_y;
		logic signed [31:0] out_z;
		logic [2:0] status;
	} out_item_t;

	typedef struct packed {
		logic command;
		logic [5:0] key_slot;
		logic [31:0] key_time;
		logic [95:0] key_xyz;
		logic [31:0] query_time;
	} cmd_t;
endpackage

// ----- sv/kli_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module kli_ram #(
	parameter int Width = 32,
	parameter int Depth = 64
) (
	input logic clk,
	input logic we,
	input logic [$clog2(Depth)-1:0] waddr,
	input logic [Width-1:0] wdata,
	input logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0] rdata
);
	logic [Width-1:0] mem_q [Depth];
	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule

// ----- sv/kli_front.sv -----
// Front part: accepts commands into a two-entry queue.
module kli_front import kli_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input in_item_t in_item,
	output logic busy,
	input logic pop,
	output logic avail,
	output cmd_t head
);
	cmd_t q_q [2];
	logic rd_q, wr_q;
	logic [1:0] cnt_q;
	logic push;
	assign busy = cnt_q == 2'd2;
	assign push = start && !busy;
	assign avail = cnt_q != 2'd0;
	assign head = q_q[rd_q];
	always_ff @(posedge clk) begin
		if (push) q_q[wr_q] <= '{in_item.command, in_item.key_slot, in_item.key_time,
			{in_item.key_x, in_item.key_y, in_item.key_z}, in_item.query_time};
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= 1'b0;
			wr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= !wr_q;
			if (pop) rd_q <= !rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end
endmodule

// ----- sv/kli_back.sv -----
// Back part: table storage, linear search, division and interpolation.
module kli_back import kli_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic avail,
	input cmd_t head,
	output logic pop,
	input logic [6:0] key_count,
	input logic empty_one,
	output logic done,
	output out_item_t result
);
	localparam logic [3:0] S_IDLE = 4'd0, S_RD = 4'd1, S_CHK = 4'd2, S_PREV = 4'd3,
		S_PRD = 4'd4, S_DIV = 4'd5, S_MUL = 4'd6, S_OUT = 4'd7, S_CLAMP = 4'd8;
	logic [3:0] st_q;
	logic [SlotW-1:0] raddr;
	logic [SlotW-1:0] idx_q;
	logic [31:0] t_rd;
	logic [95:0] v_rd;
	logic [31:0] t1_q;
	logic [95:0] v1_q, v0_q;
	logic [CountW-1:0] n;
	logic [5:0] cnt_q;
	logic [48:0] rem_q;
	logic [47:0] num_q;
	logic [16:0] f_q;
	logic [31:0] dt_q;
	logic [1:0] comp_q;
	logic [95:0] res_q;
	logic [2:0] stat_q;
	logic we;
	logic signed [32:0] d;
	logic signed [50:0] p;
	logic signed [31:0] v0c, v1c;
	logic [48:0] trial;

	assign n = (key_count > 7'(MaxKeys)) ? CountW'(MaxKeys) : CountW'(key_count);
	assign we = st_q == S_IDLE && avail && head.command == CMD_WRITE
		&& 32'(head.key_slot) < MaxKeys;
	assign pop = st_q == S_IDLE && avail && head.command == CMD_WRITE || st_q == S_OUT;

	kli_ram #(.Width(32), .Depth(MaxKeys)) u_t (.clk, .we, .waddr(SlotW'(head.key_slot)),
		.wdata(head.key_time), .raddr, .rdata(t_rd));
	kli_ram #(.Width(96), .Depth(MaxKeys)) u_v (.clk, .we, .waddr(SlotW'(head.key_slot)),
		.wdata(head.key_xyz), .raddr, .rdata(v_rd));

	always_comb begin
		raddr = idx_q;
		if (st_q == S_IDLE) raddr = '0;
		else if (st_q == S_PREV) raddr = idx_q - 1'b1;
	end

	assign v0c = v0_q[95 - 32*comp_q -: 32];
	assign v1c = v1_q[95 - 32*comp_q -: 32];
	assign d = 33'(v1c) - 33'(v0c);
	assign p = 51'(d) * $signed({34'd0, f_q});
	assign trial = {rem_q[47:0], num_q[47]} - {17'd0, dt_q};

	always_ff @(posedge clk) begin
		unique case (st_q)
			S_CHK: begin
				t1_q <= t_rd;
				v1_q <= v_rd;
			end
			S_PRD: begin
				v0_q <= v_rd;
				dt_q <= t1_q - t_rd;
				num_q <= {head.query_time - t_rd, 16'd0};
				rem_q <= '0;
				cnt_q <= 6'd0;
			end
			S_DIV: begin
				num_q <= {num_q[46:0], 1'b0};
				if (!trial[48]) begin
					rem_q <= trial;
					f_q <= 17'({f_q[15:0], 1'b1});
				end else begin
					rem_q <= {rem_q[47:0], num_q[47]};
					f_q <= 17'({f_q[15:0], 1'b0});
				end
				cnt_q <= cnt_q + 1'b1;
			end
			S_MUL: res_q[95 - 32*comp_q -: 32] <= v0c + 32'(p >>> 16);
			default: ;
		endcase
		if (st_q == S_IDLE) f_q <= '0;
		if (st_q == S_CLAMP) res_q <= v_rd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			idx_q <= '0;
			comp_q <= '0;
			done <= 1'b0;
			result <= '0;
			stat_q <= ST_INTERP;
		end else begin
			done <= 1'b0;
			unique case (st_q)
				S_IDLE: if (avail) begin
					if (head.command == CMD_WRITE) begin
						done <= 1'b1;
						result <= '{32'sd0, 32'sd0, 32'sd0, ST_WRITTEN};
					end else if (n == '0) begin
						done <= 1'b1;
						result <= empty_one ? '{QOne, QOne, QOne, ST_EMPTY}
							: '{32'sd0, 32'sd0, 32'sd0, ST_EMPTY};
						st_q <= S_OUT;
					end else begin
						idx_q <= '0;
						st_q <= S_RD;
					end
				end
				S_RD: st_q <= S_CHK;
				S_CHK: begin
					if (t_rd >= head.query_time) begin
						if (idx_q == '0) begin
							stat_q <= ST_FIRST;
							st_q <= S_CLAMP;
						end else st_q <= S_PREV;
					end else if (CountW'(idx_q) + 1'b1 >= n) begin
						stat_q <= ST_LAST;
						st_q <= S_CLAMP;
					end else begin
						idx_q <= idx_q + 1'b1;
						st_q <= S_RD;
					end
				end
				S_CLAMP: begin
					done <= 1'b1;
					result <= '{v_rd[95:64], v_rd[63:32], v_rd[31:0], stat_q};
					st_q <= S_OUT;
				end
				S_PREV: st_q <= S_PRD;
				S_PRD: st_q <= S_DIV;
				S_DIV: if (cnt_q == 6'd47) begin
					comp_q <= '0;
					st_q <= S_MUL;
				end
				S_MUL: begin
					if (comp_q == 2'd2) begin
						st_q <= S_OUT;
						done <= 1'b1;
						result <= '{res_q[95:64], res_q[63:32], v0c + 32'(p >>> 16),
							ST_INTERP};
					end
					comp_q <= comp_q + 1'b1;
				end
				S_OUT: st_q <= S_IDLE;
				default: st_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ----- sv/keyframe_linear_interpolator_unit.sv -----
// Path from transfer to done: a write or an empty table answers from idle; a clamp follows the
// linear search over the keys; an interpolation follows the search, the bit-serial divide and
// the multiply of each component. Throughput: one write per cycle while the back part is idle;
// an evaluation holds the back part until its command is popped, set by the search and divider.
// Results appear for one cycle with done; the receiver cannot stall.
// Asynchronous active-low reset clears the queue, control state and configuration.
module keyframe_linear_interpolator_unit import kli_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input in_item_t in_item,
	output logic done,
	output out_item_t result,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic cfg_index,
	input logic [31:0] cfg_data
);
	logic pop, avail;
	cmd_t head;
	logic [6:0] key_count_q;
	logic empty_one_q;
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_count_q <= '0;
			empty_one_q <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_KEY_COUNT: key_count_q <= cfg_data[6:0];
				CFG_EMPTY_ONE: empty_one_q <= cfg_data[0];
				default: ;
			endcase
		end
	end
	kli_front u_front (.clk, .arst_n, .start, .in_item, .busy, .pop, .avail, .head);
	kli_back u_back (.clk, .arst_n, .avail, .head, .pop, .key_count(key_count_q),
		.empty_one(empty_one_q), .done, .result);
endmodule

// ----- sv/kli_checker.sv -----
// Port-level checker bound to the interpolator top level.
`include "keyframe_linear_interpolator_unit_macros.svh"
module kli_checker import kli_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic done,
	input out_item_t result
);
	`KLI_ASSERT_IMP(a_status, clk, arst_n, done, result.status <= ST_WRITTEN)
	`KLI_ASSERT_IMP(a_wzero, clk, arst_n, done && result.status == ST_WRITTEN,
		result.out_x == 0 && result.out_y == 0 && result.out_z == 0)
	`KLI_ASSERT_NEXT(a_nodone_back, clk, arst_n, done && result.status != ST_WRITTEN, !done)
endmodule
bind keyframe_linear_interpolator_unit kli_checker u_chk (.clk, .arst_n, .done, .result);
